// File: rtl/spatial_grid_nearest_free_cell_macros.svh
// Assertion macros used by the spatial grid datapath
`ifndef SPATIAL_GRID_NEAREST_FREE_CELL_MACROS_SVH
`define SPATIAL_GRID_NEAREST_FREE_CELL_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SGNFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SGNFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sgnfc_pkg.sv
// Shared types, constants and helpers of the spatial grid block
`default_nettype none

package sgnfc_pkg;

  localparam int CW            = 4;
  localparam int GRID_CELLS    = 1 << CW;
  localparam int CELL_SPAN     = 1024;
  localparam int CELL_SHIFT    = $clog2(CELL_SPAN);
  localparam int HALF_EXTENT   = 8192;
  localparam int SEARCH_SHELLS = 3;
  localparam int RW            = $clog2(SEARCH_SHELLS + 1);
  localparam int STORE_DEPTH   = GRID_CELLS * GRID_CELLS * GRID_CELLS;
  localparam int AW            = $clog2(STORE_DEPTH);
  localparam int ID_W          = 16;
  localparam int POS_W         = 16;
  localparam int NB_W          = 6;

  localparam logic [ID_W-1:0] EMPTY_ID = 16'hFFFF;
  localparam logic [NB_W-1:0] NB_RESET = 6'd63;

  typedef logic [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_PLACED      = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_NEIGHBOR    = 3'd2,
    ST_NO_NEIGHBOR = 3'd3,
    ST_CLEARED     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SRC_HOLD  = 2'd0,
    SRC_STAGE = 2'd1,
    SRC_HOME  = 2'd2,
    SRC_ZERO  = 2'd3
  } src_e;

  typedef struct packed {
    logic    sweep;
    logic    start;
    logic    step;
    logic    kill;
    logic    wr;
    logic    hold_load;
    logic    emit;
    src_e    emit_src;
    status_e emit_status;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic stg_hit;
    logic scan_busy;
    logic hold_vld;
    logic out_free;
    op_e  op;
  } sts_t;

  // Offset, clamp and scale down one axis of a position to a cell coordinate
  function automatic coord_t home_coord(input logic [POS_W-1:0] pos);
    logic signed [POS_W:0] p;
    logic signed [POS_W:0] pc;
    p  = $signed({pos[POS_W-1], pos}) + (POS_W+1)'(HALF_EXTENT);
    pc = p;
    if (p < (POS_W+1)'(1)) begin
      pc = (POS_W+1)'(1);
    end else if (p > (POS_W+1)'(2 * HALF_EXTENT - 1)) begin
      pc = (POS_W+1)'(2 * HALF_EXTENT - 1);
    end
    return pc[CELL_SHIFT +: CW];
  endfunction

endpackage

`default_nettype wire

// File: rtl/spatial_grid_nearest_free_cell.sv
// Top level of the spatial grid block: register port, controller and datapath
//
// Usage:
//   Requests enter on the in_valid_i/in_ready_o channel: operation_i selects
//   clear, insert or query, with object_id_i and pos_x/y/z_i. Results leave on
//   out_valid_o/out_ready_i with status, neighbour id, cell and a last flag.
//   One request is worked on at a time; in_ready_o is high while idle, also
//   when the last result still sits in the output register.
//   Insert and query walk the home cell and shells of radius 1 and 2, one cell
//   per cycle through the single memory read port while the receiver keeps up,
//   visiting up to 125 cells per request. A clear sweeps all 4096 cells, one
//   per cycle, then reports once.
//   After reset a clearing pass over all 4096 cells runs with in_ready_o low;
//   register writes are taken throughout.
//   When the receiver stalls, the walk halts on the next result to deliver
//   and resumes as out_ready_i returns; nothing is lost.
//   max_neighbors sits at byte address 0 of the APB port (reset 63).
`default_nettype none

module spatial_grid_nearest_free_cell (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  operation_i,
  input  wire  [15:0] object_id_i,
  input  wire  [15:0] pos_x_i,
  input  wire  [15:0] pos_y_i,
  input  wire  [15:0] pos_z_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] neighbor_id_o,
  output logic [3:0]  cell_x_o,
  output logic [3:0]  cell_y_o,
  output logic [3:0]  cell_z_o,
  output logic        last_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sgnfc_pkg::*;

  localparam logic REG_MAX_NEIGHBORS = 1'b0;

  logic [NB_W-1:0] max_nb_q;
  cmd_t            cmd;
  sts_t            sts;
  status_e         out_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_NEIGHBORS) ? {26'b0, max_nb_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_nb_q <= NB_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_NEIGHBORS) begin
      max_nb_q <= pwdata[NB_W-1:0];
    end
  end

  sgnfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_e'(operation_i)),
    .max_nb_i   (max_nb_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgnfc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_e'(operation_i)),
    .id_i         (object_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .out_ready_i  (out_ready_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_status_o (out_status),
    .out_id_o     (neighbor_id_o),
    .out_x_o      (cell_x_o),
    .out_y_o      (cell_y_o),
    .out_z_o      (cell_z_o),
    .out_last_o   (last_o)
  );

  assign status_o = out_status;

endmodule

`default_nettype wire

// File: rtl/sgnfc_ctrl.sv
// Controller state machine: sweeps, walk sequencing and result ordering
`default_nettype none

module sgnfc_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  sgnfc_pkg::op_e               op_i,
  input  wire  [sgnfc_pkg::NB_W-1:0]   max_nb_i,
  input  sgnfc_pkg::sts_t              sts_i,
  output sgnfc_pkg::cmd_t              cmd_o
);
  import sgnfc_pkg::*;

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_CLEAR   = 3'd2;
  localparam logic [2:0] S_CLR_RES = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_DRAIN   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [NB_W-1:0] count_q, count_d;
  logic [NB_W-1:0] lim;
  logic            at_limit;

  // a limit of zero acts as one
  assign lim      = (max_nb_i == '0) ? NB_W'(1) : max_nb_i;
  assign at_limit = (count_q == lim - NB_W'(1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_CLEAR: state_d = S_CLEAR;
            OP_INSERT, OP_QUERY: begin
              cmd_o.start = 1'b1;
              count_d     = '0;
              state_d     = S_WALK;
            end
            OP_NOP: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) state_d = S_CLR_RES;
      end
      S_CLR_RES: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_src    = SRC_ZERO;
          cmd_o.emit_status = ST_CLEARED;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts_i.stg_hit) begin
          if (sts_i.op == OP_INSERT) begin
            if (sts_i.out_free) begin
              cmd_o.wr          = 1'b1;
              cmd_o.emit        = 1'b1;
              cmd_o.emit_src    = SRC_STAGE;
              cmd_o.emit_status = ST_PLACED;
              cmd_o.emit_last   = 1'b1;
              cmd_o.kill        = 1'b1;
              state_d           = S_IDLE;
            end
          end else if (!sts_i.hold_vld || sts_i.out_free) begin
            // push the held neighbour out and keep the new one back
            cmd_o.hold_load   = 1'b1;
            cmd_o.emit        = sts_i.hold_vld;
            cmd_o.emit_src    = SRC_HOLD;
            cmd_o.emit_status = ST_NEIGHBOR;
            count_d           = count_q + NB_W'(1);
            if (at_limit) begin
              cmd_o.kill = 1'b1;
              state_d    = S_DRAIN;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
        end else if (!sts_i.scan_busy) begin
          if (sts_i.op == OP_QUERY && sts_i.hold_vld) begin
            state_d = S_DRAIN;
          end else if (sts_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_src    = SRC_HOME;
            cmd_o.emit_status = (sts_i.op == OP_INSERT) ? ST_NO_FREE : ST_NO_NEIGHBOR;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_src    = SRC_HOLD;
          cmd_o.emit_status = ST_NEIGHBOR;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sgnfc_datapath.sv
// Datapath: cell memory, shell walk counters, read stage, hold and result registers
`default_nettype none
`include "spatial_grid_nearest_free_cell_macros.svh"

module sgnfc_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sgnfc_pkg::cmd_t              cmd_i,
  input  sgnfc_pkg::op_e               op_i,
  input  wire  [sgnfc_pkg::ID_W-1:0]   id_i,
  input  wire  [sgnfc_pkg::POS_W-1:0]  pos_x_i,
  input  wire  [sgnfc_pkg::POS_W-1:0]  pos_y_i,
  input  wire  [sgnfc_pkg::POS_W-1:0]  pos_z_i,
  input  wire                          out_ready_i,
  output sgnfc_pkg::sts_t              sts_o,
  output logic                         out_valid_o,
  output sgnfc_pkg::status_e           out_status_o,
  output logic [sgnfc_pkg::ID_W-1:0]   out_id_o,
  output sgnfc_pkg::coord_t            out_x_o,
  output sgnfc_pkg::coord_t            out_y_o,
  output sgnfc_pkg::coord_t            out_z_o,
  output logic                         out_last_o
);
  import sgnfc_pkg::*;

  function automatic coord_t lo_bound(input coord_t h, input logic [RW-1:0] r);
    logic [CW:0] he;
    logic [CW:0] re;
    he = {1'b0, h};
    re = (CW+1)'(r);
    return (he >= re) ? CW'(he - re) : '0;
  endfunction

  function automatic coord_t hi_bound(input coord_t h, input logic [RW-1:0] r);
    logic [CW:0] s;
    s = {1'b0, h} + (CW+1)'(r);
    return (s > (CW+1)'(GRID_CELLS - 1)) ? CW'(GRID_CELLS - 1) : s[CW-1:0];
  endfunction

  function automatic logic on_shell(input coord_t c, input coord_t h, input logic [RW-1:0] r);
    logic [CW:0] ce;
    logic [CW:0] he;
    logic [CW:0] re;
    ce = {1'b0, c};
    he = {1'b0, h};
    re = (CW+1)'(r);
    return (ce + re == he) || (ce == he + re);
  endfunction

  logic [ID_W-1:0] mem [STORE_DEPTH];

  op_e             op_q, op_d;
  logic [ID_W-1:0] id_q, id_d;
  coord_t          hx_q, hy_q, hz_q, hx_d, hy_d, hz_d;
  logic [RW-1:0]   r_q, r_d, r_nxt;
  coord_t          x_q, y_q, z_q, x_d, y_d, z_d;
  logic            scan_vld_q, scan_vld_d;
  logic [AW-1:0]   swp_q;

  logic            stg_vld_q, stg_vld_d;
  logic            stg_shell_q;
  coord_t          stg_x_q, stg_y_q, stg_z_q;
  logic [ID_W-1:0] rd_data_q;

  logic            hold_vld_q;
  logic [ID_W-1:0] hold_id_q;
  coord_t          hold_x_q, hold_y_q, hold_z_q;

  logic            out_vld_q;
  status_e         out_status_q;
  logic [ID_W-1:0] out_id_q;
  coord_t          out_x_q, out_y_q, out_z_q;
  logic            out_last_q;

  coord_t          xlo, xhi, ylo, yhi, zlo, zhi;
  logic            x_sh, y_sh, z_sh, last_r, rd_empty, out_free;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [ID_W-1:0] mem_wd;

  assign r_nxt  = r_q + RW'(1);
  assign last_r = (r_q == RW'(SEARCH_SHELLS - 1));
  assign xlo = lo_bound(hx_q, r_q);
  assign ylo = lo_bound(hy_q, r_q);
  assign zlo = lo_bound(hz_q, r_q);
  assign xhi = hi_bound(hx_q, r_q);
  assign yhi = hi_bound(hy_q, r_q);
  assign zhi = hi_bound(hz_q, r_q);
  assign x_sh = on_shell(x_q, hx_q, r_q);
  assign y_sh = on_shell(y_q, hy_q, r_q);
  assign z_sh = on_shell(z_q, hz_q, r_q);

  // walk counters: x outer, y middle, z inner; skip the hollow middle of a shell
  always_comb begin
    op_d       = op_q;
    id_d       = id_q;
    hx_d       = hx_q;
    hy_d       = hy_q;
    hz_d       = hz_q;
    r_d        = r_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    scan_vld_d = scan_vld_q;
    stg_vld_d  = stg_vld_q;
    if (cmd_i.start) begin
      op_d       = op_i;
      id_d       = id_i;
      hx_d       = home_coord(pos_x_i);
      hy_d       = home_coord(pos_y_i);
      hz_d       = home_coord(pos_z_i);
      r_d        = '0;
      x_d        = hx_d;
      y_d        = hy_d;
      z_d        = hz_d;
      scan_vld_d = 1'b1;
      stg_vld_d  = 1'b0;
    end else if (cmd_i.kill) begin
      scan_vld_d = 1'b0;
      stg_vld_d  = 1'b0;
    end else if (cmd_i.step) begin
      stg_vld_d = scan_vld_q;
      if (scan_vld_q) begin
        if (z_q != zhi) begin
          z_d = (!x_sh && !y_sh && z_q == zlo) ? zhi : z_q + CW'(1);
        end else begin
          z_d = zlo;
          if (y_q != yhi) begin
            y_d = y_q + CW'(1);
          end else begin
            y_d = ylo;
            if (x_q != xhi) begin
              x_d = x_q + CW'(1);
            end else if (last_r) begin
              scan_vld_d = 1'b0;
            end else begin
              r_d = r_nxt;
              x_d = lo_bound(hx_q, r_nxt);
              y_d = lo_bound(hy_q, r_nxt);
              z_d = lo_bound(hz_q, r_nxt);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
      stg_vld_q  <= 1'b0;
      swp_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      scan_vld_q <= scan_vld_d;
      stg_vld_q  <= stg_vld_d;
      if (cmd_i.sweep) swp_q <= swp_q + AW'(1);
      if (cmd_i.hold_load) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.emit && cmd_i.emit_src == SRC_HOLD) begin
        hold_vld_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    id_q <= id_d;
    hx_q <= hx_d;
    hy_q <= hy_d;
    hz_q <= hz_d;
    r_q  <= r_d;
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
    if (cmd_i.step) begin
      stg_x_q     <= x_q;
      stg_y_q     <= y_q;
      stg_z_q     <= z_q;
      stg_shell_q <= x_sh || y_sh || z_sh;
    end
    if (cmd_i.hold_load) begin
      hold_id_q <= rd_data_q;
      hold_x_q  <= stg_x_q;
      hold_y_q  <= stg_y_q;
      hold_z_q  <= stg_z_q;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
      unique case (cmd_i.emit_src)
        SRC_HOLD: begin
          out_id_q <= hold_id_q;
          out_x_q  <= hold_x_q;
          out_y_q  <= hold_y_q;
          out_z_q  <= hold_z_q;
        end
        SRC_STAGE: begin
          out_id_q <= EMPTY_ID;
          out_x_q  <= stg_x_q;
          out_y_q  <= stg_y_q;
          out_z_q  <= stg_z_q;
        end
        SRC_HOME: begin
          out_id_q <= EMPTY_ID;
          out_x_q  <= hx_q;
          out_y_q  <= hy_q;
          out_z_q  <= hz_q;
        end
        SRC_ZERO: begin
          out_id_q <= EMPTY_ID;
          out_x_q  <= '0;
          out_y_q  <= '0;
          out_z_q  <= '0;
        end
      endcase
    end
  end

  // cell memory: one write port (sweep or insert), one registered read port
  assign mem_we = cmd_i.sweep || cmd_i.wr;
  assign mem_wa = cmd_i.sweep ? swp_q : {stg_x_q, stg_y_q, stg_z_q};
  assign mem_wd = cmd_i.sweep ? EMPTY_ID : id_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.step) rd_data_q <= mem[{x_q, y_q, z_q}];
  end

  assign rd_empty = (rd_data_q == EMPTY_ID);
  assign out_free = !out_vld_q || out_ready_i;

  assign sts_o.sweep_done = (swp_q == AW'(STORE_DEPTH - 1));
  assign sts_o.stg_hit    = stg_vld_q && stg_shell_q &&
                            ((op_q == OP_INSERT) ? rd_empty : (!rd_empty && rd_data_q != id_q));
  assign sts_o.scan_busy  = scan_vld_q || stg_vld_q;
  assign sts_o.hold_vld   = hold_vld_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.op         = op_q;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign out_last_o   = out_last_q;

  `SGNFC_ASSERT_NOW(a_emit_free, cmd_i.emit, !out_vld_q || out_ready_i, "result register overwritten")
  `SGNFC_ASSERT_NOW(a_hold_push, cmd_i.hold_load && hold_vld_q, cmd_i.emit && cmd_i.emit_src == SRC_HOLD, "held neighbour dropped")
  `SGNFC_ASSERT_NOW(a_wr_free, cmd_i.wr, stg_vld_q && stg_shell_q && rd_data_q == EMPTY_ID, "insert into an occupied cell")
  `SGNFC_ASSERT_NEXT(a_kill_stop, cmd_i.kill, !scan_vld_q && !stg_vld_q, "walk still running after stop")

endmodule

`default_nettype wire

// File: test/grid_result_checker.sv
// Checker for the spatial grid block: mirrors the cell store and compares every result
module grid_result_checker #(
  parameter logic [2:0] NB_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] object_id_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] neighbor_id_i,
  input  logic [3:0]  cell_x_i,
  input  logic [3:0]  cell_y_i,
  input  logic [3:0]  cell_z_i,
  input  logic        last_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);
  import sgnfc_pkg::*;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] nid;
    coord_t          cx;
    coord_t          cy;
    coord_t          cz;
    logic            last;
  } grid_result_t;

  logic [ID_W-1:0] cell_model [STORE_DEPTH];
  logic [NB_W-1:0] nb_limit;
  grid_result_t    due_results [$];
  grid_result_t    walk_hits [$];

  function automatic coord_t axis_cell(input logic [POS_W-1:0] pos);
    int p;
    p = int'($signed(pos)) + HALF_EXTENT;
    if (p < 1) p = 1;
    if (p > 2 * HALF_EXTENT - 1) p = 2 * HALF_EXTENT - 1;
    return coord_t'((p / CELL_SPAN) % GRID_CELLS);
  endfunction

  function automatic grid_result_t make_result(input status_e st, input logic [ID_W-1:0] nid,
                                               input int x, input int y, input int z,
                                               input logic last);
    grid_result_t r;
    r.status = st;
    r.nid    = nid;
    r.cx     = coord_t'(x);
    r.cy     = coord_t'(y);
    r.cz     = coord_t'(z);
    r.last   = last;
    return r;
  endfunction

  function automatic void clear_cells();
    for (int i = 0; i < STORE_DEPTH; i++) cell_model[i] = EMPTY_ID;
  endfunction

  // Look at one cell of the walk; returns 1 when the walk must stop
  function automatic bit probe_cell(input op_e op, input logic [ID_W-1:0] id, input int x,
                                    input int y, input int z, input int limit, inout int hits);
    int              idx;
    logic [ID_W-1:0] held;
    idx  = (x * GRID_CELLS + y) * GRID_CELLS + z;
    held = cell_model[idx];
    if (op == OP_INSERT) begin
      if (held != EMPTY_ID) return 1'b0;
      cell_model[idx] = id;
      walk_hits.push_back(make_result(ST_PLACED, EMPTY_ID, x, y, z, 1'b1));
      hits = 1;
      return 1'b1;
    end
    if (held == EMPTY_ID || held == id) return 1'b0;
    walk_hits.push_back(make_result(ST_NEIGHBOR, held, x, y, z, 1'b0));
    hits++;
    return hits >= limit;
  endfunction

  // Home cell first, then full shells of growing radius clipped at the grid edge
  function automatic int walk_grid(input op_e op, input logic [ID_W-1:0] id, input int hx,
                                   input int hy, input int hz, input int limit);
    int hits;
    int lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    hits = 0;
    walk_hits.delete();
    if (probe_cell(op, id, hx, hy, hz, limit, hits)) return hits;
    for (int r = 1; r < SEARCH_SHELLS; r++) begin
      lo_x = (hx - r < 0) ? 0 : hx - r;
      lo_y = (hy - r < 0) ? 0 : hy - r;
      lo_z = (hz - r < 0) ? 0 : hz - r;
      hi_x = (hx + r > GRID_CELLS - 1) ? GRID_CELLS - 1 : hx + r;
      hi_y = (hy + r > GRID_CELLS - 1) ? GRID_CELLS - 1 : hy + r;
      hi_z = (hz + r > GRID_CELLS - 1) ? GRID_CELLS - 1 : hz + r;
      for (int x = lo_x; x <= hi_x; x++) begin
        for (int y = lo_y; y <= hi_y; y++) begin
          for (int z = lo_z; z <= hi_z; z++) begin
            if (x == hx - r || x == hx + r || y == hy - r || y == hy + r ||
                z == hz - r || z == hz + r) begin
              if (probe_cell(op, id, x, y, z, limit, hits)) return hits;
            end
          end
        end
      end
    end
    return hits;
  endfunction

  function automatic void predict_request(input op_e op, input logic [ID_W-1:0] id,
                                          input logic [POS_W-1:0] px,
                                          input logic [POS_W-1:0] py,
                                          input logic [POS_W-1:0] pz);
    int           hx, hy, hz, hits, limit;
    grid_result_t r;
    hx = axis_cell(px);
    hy = axis_cell(py);
    hz = axis_cell(pz);
    case (op)
      OP_CLEAR: begin
        clear_cells();
        due_results.push_back(make_result(ST_CLEARED, EMPTY_ID, 0, 0, 0, 1'b1));
      end
      OP_INSERT: begin
        hits = walk_grid(OP_INSERT, id, hx, hy, hz, 1);
        if (hits == 0) due_results.push_back(make_result(ST_NO_FREE, EMPTY_ID, hx, hy, hz, 1'b1));
        else due_results.push_back(walk_hits[0]);
      end
      OP_QUERY: begin
        limit = (nb_limit == '0) ? 1 : int'(nb_limit);
        hits  = walk_grid(OP_QUERY, id, hx, hy, hz, limit);
        if (hits == 0) begin
          due_results.push_back(make_result(ST_NO_NEIGHBOR, EMPTY_ID, hx, hy, hz, 1'b1));
        end else begin
          for (int i = 0; i < walk_hits.size(); i++) begin
            r      = walk_hits[i];
            r.last = (i == walk_hits.size() - 1);
            due_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                      input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors_o++;
    end
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
    nb_limit  = NB_RESET;
    clear_cells();
  end

  always @(posedge clk_i) begin
    grid_result_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == NB_ADDR) nb_limit = pwdata[NB_W-1:0];
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d, neighbor_id %0d, cell %0d/%0d/%0d",
                 status_i, neighbor_id_i, cell_x_i, cell_y_i, cell_z_i);
          errors_o++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("neighbor_id", want.nid, neighbor_id_i);
          check_field("cell_x", want.cx, cell_x_i);
          check_field("cell_y", want.cy, cell_y_i);
          check_field("cell_z", want.cz, cell_z_i);
          check_field("last", want.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i)
        predict_request(op_e'(operation_i), object_id_i, pos_x_i, pos_y_i, pos_z_i);
      pending_o = due_results.size();
    end
  end

endmodule

// File: test/tb_spatial_grid_nearest_free_cell.sv
// Testbench top for the spatial grid block: request stimulus, output stalls and verdict
module tb_spatial_grid_nearest_free_cell;
  import sgnfc_pkg::*;

  typedef enum {HOME_INNER, HOME_CORNER, HOME_KEEP} home_pick_e;

  localparam logic [2:0] MAX_NB_ADDR   = 3'd0;
  localparam int         IDLE_PCT      = 38;
  localparam int         SETTLE_CYCLES = 32;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         HOLD_AFTER    = 60;
  localparam int         CYCLE_LIMIT   = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [15:0] object_id_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [15:0] pos_z_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [15:0] neighbor_id_o;
  logic [3:0]  cell_x_o;
  logic [3:0]  cell_y_o;
  logic [3:0]  cell_z_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit     calm;
  int     hold_left;
  bit     held_once;
  int     results_seen;
  int     errors;
  int     pending;
  coord_t home_x, home_y, home_z;

  spatial_grid_nearest_free_cell u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .object_id_i   (object_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .neighbor_id_o (neighbor_id_o),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .cell_z_o      (cell_z_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  grid_result_checker #(.NB_ADDR(MAX_NB_ADDR)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .operation_i   (operation_i),
    .object_id_i   (object_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .neighbor_id_i (neighbor_id_o),
    .cell_x_i      (cell_x_o),
    .cell_y_i      (cell_y_o),
    .cell_z_i      (cell_z_o),
    .last_i        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) results_seen++;
  end

  // Receiver: random stalls, one long hold-off once results are flowing
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request; returns just after the edge that accepts it
  task automatic send_req(input op_e op, input logic [15:0] id, input logic [15:0] px,
                          input logic [15:0] py, input logic [15:0] pz);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    object_id_i <= id;
    pos_x_i     <= px;
    pos_y_i     <= py;
    pos_z_i     <= pz;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every result, then let a request with no result finish
  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_nb(input logic [NB_W-1:0] value);
    drain_requests();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_NB_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random position that lands in the given cell after offset and clamp
  function automatic logic [15:0] pos_in_cell(input int c);
    int lo_cap, hi_base;
    lo_cap  = CELL_SPAN - 1 - HALF_EXTENT;
    hi_base = (GRID_CELLS - 1) * CELL_SPAN - HALF_EXTENT;
    if (c <= 0) return 16'(-32768 + int'($urandom_range(lo_cap + 32768)));
    if (c >= GRID_CELLS - 1) return 16'(hi_base + int'($urandom_range(32767 - hi_base)));
    return 16'(c * CELL_SPAN - HALF_EXTENT + int'($urandom_range(CELL_SPAN - 1)));
  endfunction

  function automatic logic [15:0] near_pos(input coord_t c);
    int k;
    k = int'(c);
    if ($urandom_range(3) == 0) begin
      k = k + int'($urandom_range(4)) - 2;
      if (k < 0) k = 0;
      if (k > GRID_CELLS - 1) k = GRID_CELLS - 1;
    end
    return pos_in_cell(k);
  endfunction

  // Mostly a few small ids so that queries meet their own entries
  function automatic logic [15:0] pick_id();
    int dice;
    dice = $urandom_range(99);
    if (dice < 60) return 16'($urandom_range(7));
    if (dice < 95) return 16'($urandom_range(65534));
    return EMPTY_ID;
  endfunction

  task automatic run_cluster(input int n_items, input int insert_pct, input home_pick_e pick);
    int dice;
    case (pick)
      HOME_INNER: begin
        home_x = coord_t'($urandom_range(GRID_CELLS - 3, 2));
        home_y = coord_t'($urandom_range(GRID_CELLS - 3, 2));
        home_z = coord_t'($urandom_range(GRID_CELLS - 3, 2));
      end
      HOME_CORNER: begin
        home_x = $urandom_range(1) ? coord_t'(GRID_CELLS - 1) : '0;
        home_y = $urandom_range(1) ? coord_t'(GRID_CELLS - 1) : '0;
        home_z = $urandom_range(1) ? coord_t'(GRID_CELLS - 1) : '0;
      end
      default: ;
    endcase
    repeat (n_items) begin
      dice = $urandom_range(99);
      if (dice < 2 && pick != HOME_KEEP) begin
        send_req(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (dice < 5) begin
        send_req(OP_NOP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (dice < 13) begin
        send_req($urandom_range(1) ? OP_INSERT : OP_QUERY, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
      end else if (dice < 13 + insert_pct) begin
        send_req(OP_INSERT, pick_id(), near_pos(home_x), near_pos(home_y), near_pos(home_z));
      end else begin
        send_req(OP_QUERY, pick_id(), near_pos(home_x), near_pos(home_y), near_pos(home_z));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_NOP;
    object_id_i  = '0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    pos_z_i      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_left    = 0;
    held_once    = 1'b0;
    results_seen = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty grid at both extremes, then fill around the corners and the centre
    send_req(OP_QUERY, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_req(OP_QUERY, 16'hFFFE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_req(OP_INSERT, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_req(OP_INSERT, 16'hFFFE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_req(OP_INSERT, 16'h1234, 16'(-8192), 16'(-8191), 16'(8191));
    send_req(OP_INSERT, 16'h1234, 16'(8192), 16'h0000, 16'hFFFF);
    // an empty-marker id is placed but the cell still reads as free
    send_req(OP_INSERT, EMPTY_ID, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_QUERY, 16'h0007, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_INSERT, 16'h00A5, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_INSERT, 16'h5A00, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_INSERT, 16'h00A5, 16'd1023, 16'h0000, 16'h0000);
    send_req(OP_QUERY, 16'h00A5, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_QUERY, 16'h0003, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_QUERY, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_req(OP_QUERY, 16'h0001, 16'h8000, 16'h8000, 16'h8000);
    send_req(OP_QUERY, EMPTY_ID, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_req(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(OP_CLEAR, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_req(OP_QUERY, 16'h0003, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_INSERT, 16'h0000, 16'(-7169), 16'(7168), 16'hFFFF);

    // Dense interior fill with no idling, then truncated queries at the same spot
    write_max_nb(NB_RESET);
    calm = 1'b1;
    run_cluster(80, 80, HOME_INNER);
    calm = 1'b0;
    write_max_nb(NB_W'($urandom_range(62, 2)));
    run_cluster(20, 15, HOME_KEEP);
    write_max_nb(6'd63);
    run_cluster(15, 10, HOME_KEEP);
    // a zero limit behaves as one; the corner walk fills up and overflows
    write_max_nb('0);
    run_cluster(45, 80, HOME_CORNER);
    write_max_nb(6'd1);
    run_cluster(30, 50, HOME_INNER);

    drain_requests();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sgnfc_pkg.sv
rtl/sgnfc_ctrl.sv
rtl/sgnfc_datapath.sv
rtl/spatial_grid_nearest_free_cell.sv
test/grid_result_checker.sv
test/tb_spatial_grid_nearest_free_cell.sv
